### rtl/bee_pkg.sv
// byte escape encoder package: widths, character constants, expansion types
// and the function that turns one raw byte into its escaped byte sequence
// no dependencies
package bee_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned MaxSeq  = 4;
  localparam int unsigned SeqIdxW = $clog2(MaxSeq);

  localparam logic [ByteW-1:0] EscResetVal = 8'h5C;
  localparam logic [ByteW-1:0] QuoteChar   = 8'h22;
  localparam logic [ByteW-1:0] DigitZero   = 8'h30;

  localparam logic [ByteW-1:0] CharNl  = 8'h0A;
  localparam logic [ByteW-1:0] CharTab = 8'h09;
  localparam logic [ByteW-1:0] CharBel = 8'h07;
  localparam logic [ByteW-1:0] CharBs  = 8'h08;
  localparam logic [ByteW-1:0] CharCr  = 8'h0D;
  localparam logic [ByteW-1:0] CharFf  = 8'h0C;
  localparam logic [ByteW-1:0] CharVt  = 8'h0B;

  localparam logic [ByteW-1:0] LetterN = 8'h6E;
  localparam logic [ByteW-1:0] LetterT = 8'h74;
  localparam logic [ByteW-1:0] LetterA = 8'h61;
  localparam logic [ByteW-1:0] LetterB = 8'h62;
  localparam logic [ByteW-1:0] LetterR = 8'h72;
  localparam logic [ByteW-1:0] LetterF = 8'h66;
  localparam logic [ByteW-1:0] LetterV = 8'h76;

  typedef struct packed {
    logic [MaxSeq-1:0][ByteW-1:0] seq;       // seq[0] goes out first
    logic [SeqIdxW-1:0]           last_idx;  // index of the final byte
  } exp_t;

  function automatic exp_t expand(input logic [ByteW-1:0] c, input logic [ByteW-1:0] esc);
    exp_t r;
    r.seq      = '0;
    r.last_idx = '0;
    r.seq[0]   = esc;
    if (c == QuoteChar || c == esc) begin
      r.seq[1]   = c;
      r.last_idx = SeqIdxW'(1);
    end else if ((c >= 8'h20 && c <= 8'h7E) || c >= 8'hA0) begin
      r.seq[0]   = c;
      r.last_idx = SeqIdxW'(0);
    end else begin
      r.last_idx = SeqIdxW'(1);
      case (c)
        CharNl:  r.seq[1] = LetterN;
        CharTab: r.seq[1] = LetterT;
        CharBel: r.seq[1] = LetterA;
        CharBs:  r.seq[1] = LetterB;
        CharCr:  r.seq[1] = LetterR;
        CharFf:  r.seq[1] = LetterF;
        CharVt:  r.seq[1] = LetterV;
        default: begin
          r.seq[1]   = DigitZero + {6'b0, c[7:6]};
          r.seq[2]   = DigitZero + {5'b0, c[5:3]};
          r.seq[3]   = DigitZero + {5'b0, c[2:0]};
          r.last_idx = SeqIdxW'(3);
        end
      endcase
    end
    return r;
  endfunction

endpackage

### rtl/bee_in_if.sv
// input channel of the byte escape encoder: one raw byte per transfer
// depends on bee_pkg
interface bee_in_if
  import bee_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             in_end;

  modport source (output valid, output in_byte, output in_end, input ready);
  modport sink   (input valid, input in_byte, input in_end, output ready);
endinterface

### rtl/bee_out_if.sv
// output channel of the byte escape encoder: one escaped byte per transfer
// depends on bee_pkg
interface bee_out_if
  import bee_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             run_last;
  logic             string_end;

  modport source (output valid, output out_byte, output run_last, output string_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input string_end,
                  output ready);
endinterface

### rtl/bee_cfg_if.sv
// configuration write channel of the byte escape encoder: escape character
// depends on bee_pkg
interface bee_cfg_if
  import bee_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/byte_escape_encoder_top.sv
// byte escape encoder: expands raw string bytes into C-style escaped text
// depends on bee_pkg, bee_in_if, bee_out_if, bee_cfg_if
//
// usage:
//   in_i   takes one raw byte per transfer, in_end marks the last string byte
//   out_o  gives one escaped byte per transfer; run_last marks the final byte
//          of each input, string_end the final byte of the whole string
//   cfg_i  writes the escape character; always ready, write only while idle
// path: each input is expanded into the expansion buffer, then the output register
// throughput: an input expands to 1, 2 or 4 output bytes, one per cycle
//   unless a low out_o.ready stalls them, through the single output byte register;
//   the next input is taken in the cycle the last byte of the current one
//   moves to the output register
// reset: escape character returns to backslash, both stages empty
// stall: while out_o.ready is low the output register holds, the expansion
//   buffer behind it holds, and in_i.ready drops once the buffer is full
module byte_escape_encoder_top
  import bee_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  bee_in_if.sink    in_i,
  bee_out_if.source out_o,
  bee_cfg_if.sink   cfg_i
);

  logic [ByteW-1:0] esc_q;

  exp_t               buf_q;
  logic [SeqIdxW-1:0] idx_q;
  logic               buf_end_q;
  logic               buf_valid_q;

  logic [ByteW-1:0] out_byte_q;
  logic             run_last_q;
  logic             string_end_q;
  logic             out_valid_q;

  logic out_free;
  logic mv;
  logic buf_done;
  logic in_xfer;
  exp_t exp_d;

  assign out_free = !out_valid_q || out_o.ready;
  assign mv       = buf_valid_q && out_free;
  assign buf_done = mv && (idx_q == buf_q.last_idx);
  assign in_xfer  = in_i.valid && in_i.ready;
  assign exp_d    = expand(in_i.in_byte, esc_q);

  assign in_i.ready  = !buf_valid_q || buf_done;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid      = out_valid_q;
  assign out_o.out_byte   = out_byte_q;
  assign out_o.run_last   = run_last_q;
  assign out_o.string_end = string_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= EscResetVal;
    end else if (cfg_i.valid) begin
      esc_q <= cfg_i.data;
    end
  end

  // expansion buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (in_xfer) begin
      buf_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (buf_done) begin
      buf_valid_q <= 1'b0;
    end else if (mv) begin
      idx_q <= idx_q + SeqIdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      buf_q     <= exp_d;
      buf_end_q <= in_i.in_end;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= buf_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv) begin
      out_byte_q   <= buf_q.seq[idx_q];
      run_last_q   <= (idx_q == buf_q.last_idx);
      string_end_q <= (idx_q == buf_q.last_idx) && buf_end_q;
    end
  end

endmodule

### tb/bee_escape_check.sv
// byte escape encoder checker: follows the escape register, predicts the escaped
// bytes for every input transfer and compares them with the output transfers
// depends on bee_pkg
module bee_escape_check
  import bee_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             in_end_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [ByteW-1:0] out_byte_i,
  input  logic             run_last_i,
  input  logic             string_end_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [ByteW-1:0] cfg_data_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  localparam logic [ByteW-1:0] PrintLo = 8'h20;
  localparam logic [ByteW-1:0] PrintHi = 8'h7E;
  localparam logic [ByteW-1:0] UpperLo = 8'hA0;

  typedef struct packed {
    logic [ByteW-1:0] text;
    logic             run_last;
    logic             string_end;
  } escaped_byte_t;

  escaped_byte_t    escaped_q [$];
  logic [ByteW-1:0] esc_char;

  function automatic logic [ByteW-1:0] control_letter(input logic [ByteW-1:0] c);
    case (c)
      CharNl:  return LetterN;
      CharTab: return LetterT;
      CharBel: return LetterA;
      CharBs:  return LetterB;
      CharCr:  return LetterR;
      CharFf:  return LetterF;
      CharVt:  return LetterV;
      default: return '0;
    endcase
  endfunction

  function automatic void predict_escape(input logic [ByteW-1:0] c, input logic end_flag);
    logic [ByteW-1:0] seq [MaxSeq];
    int               n;
    escaped_byte_t    e;
    n = 0;
    if (c == QuoteChar || c == esc_char) begin
      seq[0] = esc_char;
      seq[1] = c;
      n = 2;
    end else if ((c >= PrintLo && c <= PrintHi) || c >= UpperLo) begin
      seq[0] = c;
      n = 1;
    end else if (control_letter(c) != '0) begin
      seq[0] = esc_char;
      seq[1] = control_letter(c);
      n = 2;
    end else begin
      seq[0] = esc_char;
      seq[1] = DigitZero + ByteW'(c[7:6]);
      seq[2] = DigitZero + ByteW'(c[5:3]);
      seq[3] = DigitZero + ByteW'(c[2:0]);
      n = 4;
    end
    for (int k = 0; k < n; k++) begin
      e.text       = seq[k];
      e.run_last   = (k == n - 1);
      e.string_end = (k == n - 1) && end_flag;
      escaped_q.push_back(e);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    escaped_byte_t want;
    if (!rst_ni) begin
      esc_char = EscResetVal;
      escaped_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (escaped_q.size() == 0) begin
          $error("unexpected output transfer: out_byte %h", out_byte_i);
          fail_count_o++;
        end else begin
          want = escaped_q.pop_front();
          if (out_byte_i !== want.text) begin
            $error("out_byte: expected %h, actual %h", want.text, out_byte_i);
            fail_count_o++;
          end
          if (run_last_i !== want.run_last) begin
            $error("run_last: expected %b, actual %b", want.run_last, run_last_i);
            fail_count_o++;
          end
          if (string_end_i !== want.string_end) begin
            $error("string_end: expected %b, actual %b", want.string_end, string_end_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) esc_char = cfg_data_i;
      if (in_valid_i && in_ready_i) predict_escape(in_byte_i, in_end_i);
      pending_o = escaped_q.size();
    end
  end

endmodule

### tb/tb_byte_escape_encoder_top.sv
// byte escape encoder testbench top: clock, reset, directed and random input
// transfers under several escape characters, random stalls, final verdict
// depends on bee_pkg, the three channel interfaces, byte_escape_encoder_top, bee_escape_check
module tb_byte_escape_encoder_top
  import bee_pkg::*;
();

  localparam int unsigned PhaseItems = 19;
  localparam logic [ByteW-1:0] HighCtrlLo = 8'h7F;
  localparam logic [ByteW-1:0] HighCtrlHi = 8'h9F;
  localparam logic [ByteW-1:0] LowCtrlHi  = 8'h1F;
  localparam logic [ByteW-1:0] PercentEsc = 8'h25;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        idle_en = 1'b1;
  int unsigned stall_left = 0;
  int unsigned fail_count;
  int unsigned pending;
  logic [ByteW-1:0] cur_esc = EscResetVal;

  logic [ByteW-1:0] corner_bytes [0:19] = '{
    8'h22, 8'h5C, 8'h20, 8'h7E, 8'h7F, 8'h80, 8'h9F, 8'hA0, 8'hFF, 8'h00,
    8'h1F, 8'h0A, 8'h09, 8'h07, 8'h08, 8'h0D, 8'h0C, 8'h0B, 8'h41, 8'h01
  };
  logic [ByteW-1:0] phase_esc [0:4];

  bee_in_if  in_ch ();
  bee_out_if out_ch ();
  bee_cfg_if cfg_ch ();

  byte_escape_encoder_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  bee_escape_check escape_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_byte_i    (in_ch.in_byte),
    .in_end_i     (in_ch.in_end),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_byte_i   (out_ch.out_byte),
    .run_last_i   (out_ch.run_last),
    .string_end_i (out_ch.string_end),
    .cfg_valid_i  (cfg_ch.valid),
    .cfg_ready_i  (cfg_ch.ready),
    .cfg_data_i   (cfg_ch.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #6 clk = ~clk;

  // output stalls in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_raw(input logic [ByteW-1:0] b, input logic end_flag);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_end  <= end_flag;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_escape(input logic [ByteW-1:0] v);
    in_ch.valid <= 1'b0;
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_esc = v;
  endtask

  function automatic logic [ByteW-1:0] pick_byte(input logic [ByteW-1:0] esc);
    case ($urandom_range(0, 7))
      0:       return esc;
      1:       return QuoteChar;
      2:       return ByteW'($urandom_range(CharBel, CharCr));
      3:       return ByteW'($urandom_range(0, LowCtrlHi));
      4:       return ByteW'($urandom_range(HighCtrlLo, HighCtrlHi));
      default: return ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    in_ch.in_end  = 1'b0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    phase_esc[0] = EscResetVal;
    phase_esc[1] = 8'h00;
    phase_esc[2] = 8'hFF;
    phase_esc[3] = PercentEsc;
    phase_esc[4] = ByteW'($urandom_range(0, 255));
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner bytes under the reset escape
    foreach (corner_bytes[i]) send_raw(corner_bytes[i], i == 18 || i == 19);

    // escape equal to nul, to an upper byte and to a control byte
    write_escape(8'h00);
    send_raw(8'h00, 1'b0);
    send_raw(8'h5C, 1'b0);
    send_raw(8'h01, 1'b1);
    write_escape(8'hFF);
    send_raw(8'hFF, 1'b0);
    send_raw(QuoteChar, 1'b1);
    write_escape(CharNl);
    send_raw(CharNl, 1'b0);
    send_raw(CharTab, 1'b1);

    for (int p = 0; p < 5; p++) begin
      write_escape(phase_esc[p]);
      if (p == 4) idle_en = 1'b0;
      for (int i = 0; i < PhaseItems; i++)
        send_raw(pick_byte(cur_esc), $urandom_range(0, 7) == 0);
    end

    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_byte_escape_encoder_top passed");
    end else begin
      $display("tb_byte_escape_encoder_top failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_byte_escape_encoder_top failed");
    $finish;
  end

endmodule
